[rtl/tnaa_pkg.sv]
// ---------------------------------------------------------------------------
// tnaa_pkg
// Shared types and constants for the triangle normal and area pipeline.
// ---------------------------------------------------------------------------
package tnaa_pkg;

  localparam int CoordW  = 24;
  localparam int EdgeW   = 25;
  localparam int ProdW   = 50;
  localparam int CrossW  = 51;
  localparam int MagW    = 50;
  localparam int HalfW   = 25;
  localparam int SqW     = 100;
  localparam int LenSqW  = 102;
  localparam int GuardW  = 13;
  localparam int RadW    = 128;
  localparam int RootW   = 64;
  localparam int QuotW   = 31;
  localparam int UnitW   = 32;
  localparam int AreaW   = 50;
  localparam int RemW    = 64;
  localparam int LanesN  = 3;

  typedef struct packed {
    logic signed [CoordW-1:0] p0_x;
    logic signed [CoordW-1:0] p0_y;
    logic signed [CoordW-1:0] p0_z;
    logic signed [CoordW-1:0] p1_x;
    logic signed [CoordW-1:0] p1_y;
    logic signed [CoordW-1:0] p1_z;
    logic signed [CoordW-1:0] p2_x;
    logic signed [CoordW-1:0] p2_y;
    logic signed [CoordW-1:0] p2_z;
  } tri_in_t;

  typedef struct packed {
    logic signed [UnitW-1:0] unit_x;
    logic signed [UnitW-1:0] unit_y;
    logic signed [UnitW-1:0] unit_z;
    logic [AreaW-1:0]        tri_area;
    logic                    degenerate;
  } tri_out_t;

  // travels alongside the square root
  typedef struct packed {
    logic [LanesN-1:0][MagW-1:0] mag;
    logic [LanesN-1:0]           neg;
    logic                        degen;
  } root_side_t;

  // travels alongside the dividers
  typedef struct packed {
    logic [LanesN-1:0] neg;
    logic              degen;
    logic [AreaW-1:0]  area;
  } div_side_t;

endpackage

[rtl/tnaa_front.sv]
// ---------------------------------------------------------------------------
// tnaa_front
// Edge vectors, cross product, magnitudes and squared length (five stages).
// ---------------------------------------------------------------------------
module tnaa_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  tnaa_pkg::tri_in_t   vtx,
  output logic                out_valid,
  output logic [tnaa_pkg::LenSqW-1:0] len_sq,
  output tnaa_pkg::root_side_t side
);
  import tnaa_pkg::*;

  logic [4:0] valid;

  logic signed [EdgeW-1:0] ax, ay, az, bx, by, bz;
  logic signed [ProdW-1:0] pr [0:5];
  logic signed [CrossW-1:0] cr [0:2];
  logic [MagW-1:0]   mag_c [0:2];
  logic [LanesN-1:0] neg_c;
  logic [ProdW-1:0]  hh [0:2];
  logic [ProdW-1:0]  hl [0:2];
  logic [ProdW-1:0]  ll [0:2];
  logic [MagW-1:0]   mag4 [0:2];
  logic [LanesN-1:0] neg4;
  logic [SqW-1:0]    sq [0:2];
  logic [LenSqW-1:0] l2;
  logic [MagW-1:0]   mag5 [0:2];
  logic [LanesN-1:0] neg5;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[3:0], in_valid};
    end
  end

  // stage 1: edges from vertex 0
  always_ff @(posedge clk) begin
    ax <= $signed({vtx.p1_x[CoordW-1], vtx.p1_x}) - $signed({vtx.p0_x[CoordW-1], vtx.p0_x});
    ay <= $signed({vtx.p1_y[CoordW-1], vtx.p1_y}) - $signed({vtx.p0_y[CoordW-1], vtx.p0_y});
    az <= $signed({vtx.p1_z[CoordW-1], vtx.p1_z}) - $signed({vtx.p0_z[CoordW-1], vtx.p0_z});
    bx <= $signed({vtx.p2_x[CoordW-1], vtx.p2_x}) - $signed({vtx.p0_x[CoordW-1], vtx.p0_x});
    by <= $signed({vtx.p2_y[CoordW-1], vtx.p2_y}) - $signed({vtx.p0_y[CoordW-1], vtx.p0_y});
    bz <= $signed({vtx.p2_z[CoordW-1], vtx.p2_z}) - $signed({vtx.p0_z[CoordW-1], vtx.p0_z});
  end

  // stage 2: cross-product terms
  always_ff @(posedge clk) begin
    pr[0] <= ay * bz;
    pr[1] <= az * by;
    pr[2] <= az * bx;
    pr[3] <= ax * bz;
    pr[4] <= ax * by;
    pr[5] <= ay * bx;
  end

  // stage 3: cross product
  always_ff @(posedge clk) begin
    for (int k = 0; k < LanesN; k++) begin
      cr[k] <= $signed({pr[2*k][ProdW-1], pr[2*k]}) - $signed({pr[2*k+1][ProdW-1], pr[2*k+1]});
    end
  end

  always_comb begin
    for (int k = 0; k < LanesN; k++) begin
      neg_c[k] = cr[k][CrossW-1];
      mag_c[k] = neg_c[k] ? MagW'(-cr[k]) : cr[k][MagW-1:0];
    end
  end

  // stage 4: partial products of each square
  always_ff @(posedge clk) begin
    for (int k = 0; k < LanesN; k++) begin
      hh[k]   <= mag_c[k][MagW-1:HalfW] * mag_c[k][MagW-1:HalfW];
      hl[k]   <= mag_c[k][MagW-1:HalfW] * mag_c[k][HalfW-1:0];
      ll[k]   <= mag_c[k][HalfW-1:0] * mag_c[k][HalfW-1:0];
      mag4[k] <= mag_c[k];
    end
    neg4 <= neg_c;
  end

  always_comb begin
    for (int k = 0; k < LanesN; k++) begin
      sq[k] = {hh[k], 50'd0} + {24'd0, hl[k], 26'd0} + {50'd0, ll[k]};
    end
  end

  // stage 5: squared length
  always_ff @(posedge clk) begin
    l2 <= {2'd0, sq[0]} + {2'd0, sq[1]} + {2'd0, sq[2]};
    for (int k = 0; k < LanesN; k++) begin
      mag5[k] <= mag4[k];
    end
    neg5 <= neg4;
  end

  assign out_valid  = valid[4];
  assign len_sq     = l2;
  assign side.mag   = {mag5[2], mag5[1], mag5[0]};
  assign side.neg   = neg5;
  assign side.degen = (l2 == '0);

endmodule

[rtl/tnaa_isqrt.sv]
// ---------------------------------------------------------------------------
// tnaa_isqrt
// Pipelined integer square root, one result bit per stage.
// ---------------------------------------------------------------------------
module tnaa_isqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [tnaa_pkg::RadW-1:0]    rad,
  input  tnaa_pkg::root_side_t         side_in,
  output logic                         out_valid,
  output logic [tnaa_pkg::RootW-1:0]   root,
  output tnaa_pkg::root_side_t         side_out
);
  import tnaa_pkg::*;

  logic [RadW-1:0]  xs   [0:RootW];
  logic [RadW-1:0]  res  [0:RootW];
  logic             vld  [0:RootW];
  root_side_t       sd   [0:RootW];

  assign xs[0]  = rad;
  assign res[0] = '0;
  assign vld[0] = in_valid;
  assign sd[0]  = side_in;

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    localparam logic [RadW-1:0] Bit = RadW'(1) << (2 * (RootW - 1 - k));
    logic [RadW-1:0] trial;

    assign trial = res[k] + Bit;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      sd[k+1] <= sd[k];
      if (xs[k] >= trial) begin
        xs[k+1]  <= xs[k] - trial;
        res[k+1] <= (res[k] >> 1) + Bit;
      end else begin
        xs[k+1]  <= xs[k];
        res[k+1] <= res[k] >> 1;
      end
    end
  end

  assign out_valid = vld[RootW];
  assign root      = res[RootW][RootW-1:0];
  assign side_out  = sd[RootW];

endmodule

[rtl/tnaa_divide.sv]
// ---------------------------------------------------------------------------
// tnaa_divide
// Three pipelined restoring dividers, one quotient bit per stage.
// ---------------------------------------------------------------------------
module tnaa_divide (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  input  logic [tnaa_pkg::RootW-1:0]                dvsr,
  input  logic [tnaa_pkg::LanesN-1:0][tnaa_pkg::MagW-1:0] mag,
  input  tnaa_pkg::div_side_t                       side_in,
  output logic                                      out_valid,
  output logic [tnaa_pkg::LanesN-1:0][tnaa_pkg::QuotW-1:0] quot,
  output tnaa_pkg::div_side_t                       side_out
);
  import tnaa_pkg::*;

  localparam int PreShift = 30 + GuardW - QuotW;

  logic [LanesN-1:0][RemW-1:0]  rem [0:QuotW];
  logic [LanesN-1:0][QuotW-1:0] qt  [0:QuotW];
  logic [RootW-1:0]             dv  [0:QuotW];
  logic                         vld [0:QuotW];
  div_side_t                    sd  [0:QuotW];

  // numerator is mag * 2^43; its top part starts below the divisor
  for (genvar l = 0; l < LanesN; l++) begin : g_init
    assign rem[0][l] = RemW'({mag[l], PreShift'(0)});
    assign qt[0][l]  = '0;
  end
  assign dv[0]  = dvsr;
  assign vld[0] = in_valid;
  assign sd[0]  = side_in;

  for (genvar k = 0; k < QuotW; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    for (genvar l = 0; l < LanesN; l++) begin : g_lane
      logic [RemW:0] shifted;
      assign shifted = {rem[k][l], 1'b0};

      always_ff @(posedge clk) begin
        if (shifted >= {1'b0, dv[k]}) begin
          rem[k+1][l] <= RemW'(shifted - {1'b0, dv[k]});
          qt[k+1][l]  <= {qt[k][l][QuotW-2:0], 1'b1};
        end else begin
          rem[k+1][l] <= shifted[RemW-1:0];
          qt[k+1][l]  <= {qt[k][l][QuotW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      dv[k+1] <= dv[k];
      sd[k+1] <= sd[k];
    end
  end

  assign out_valid = vld[QuotW];
  assign quot      = qt[QuotW];
  assign side_out  = sd[QuotW];

endmodule

[rtl/triangle_normal_and_area_top.sv]
// ---------------------------------------------------------------------------
// triangle_normal_and_area_top
// Unit normal (Q2.30) and area of a triangle with Q8.16 vertices.
// ---------------------------------------------------------------------------
// Usage:
//   Drive vertices and raise start; the beat is taken at a rising edge with
//   start high and busy low. Each beat yields one result beat: done is high
//   for exactly one cycle with result valid alongside it.
// Pipeline: 5 front stages, 64 square-root stages, 31 divider stages and one
//   output register lie between the accepting edge and the done cycle.
// Throughput: one triangle per cycle while busy is low; every stage is a
//   register, so a new beat may follow each cycle. The length of the pipe is
//   set by the bit-per-stage square root and division.
// Reset: synchronous rst empties the pipe; busy stays high for the cycle
//   after reset and is low from then on.
// The receiver cannot stall: done is a strobe and nothing is held back.
// Degenerate triangles (zero cross product) give zero normal, zero area and
//   the degenerate flag.
// ---------------------------------------------------------------------------
module triangle_normal_and_area_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  tnaa_pkg::tri_in_t  vertices,
  output logic               done,
  output tnaa_pkg::tri_out_t result
);
  import tnaa_pkg::*;

  logic                 f_valid;
  logic [LenSqW-1:0]    f_len_sq;
  root_side_t           f_side;
  logic                 r_valid;
  logic [RootW-1:0]     r_root;
  root_side_t           r_side;
  div_side_t            d_side_in;
  logic                 d_valid;
  logic [LanesN-1:0][QuotW-1:0] d_quot;
  div_side_t            d_side;
  logic [LanesN-1:0][UnitW-1:0] unit_next;

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  tnaa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .vtx       (vertices),
    .out_valid (f_valid),
    .len_sq    (f_len_sq),
    .side      (f_side)
  );

  tnaa_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .rad       ({f_len_sq, 26'd0}),
    .side_in   (f_side),
    .out_valid (r_valid),
    .root      (r_root),
    .side_out  (r_side)
  );

  // root carries 13 guard bits; area is half the root, so drop 14
  assign d_side_in.neg   = r_side.neg;
  assign d_side_in.degen = r_side.degen;
  assign d_side_in.area  = r_root[RootW-1:GuardW+1];

  tnaa_divide u_divide (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (r_valid),
    .dvsr      (r_root),
    .mag       (r_side.mag),
    .side_in   (d_side_in),
    .out_valid (d_valid),
    .quot      (d_quot),
    .side_out  (d_side)
  );

  always_comb begin
    for (int k = 0; k < LanesN; k++) begin
      if (d_side.degen) begin
        unit_next[k] = '0;
      end else if (d_side.neg[k]) begin
        unit_next[k] = -{1'b0, d_quot[k]};
      end else begin
        unit_next[k] = {1'b0, d_quot[k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    result.unit_x     <= unit_next[0];
    result.unit_y     <= unit_next[1];
    result.unit_z     <= unit_next[2];
    result.tri_area   <= d_side.degen ? '0 : d_side.area;
    result.degenerate <= d_side.degen;
  end

`ifndef ASSERT_OFF
  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 101))
    else $error("result beat without a matching input beat");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.degenerate |->
      result.tri_area == '0 && result.unit_x == '0 && result.unit_y == '0 &&
      result.unit_z == '0)
    else $error("degenerate beat carries non-zero fields");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    done |-> result.unit_x <= 32'sd1073741824 && result.unit_x >= -32'sd1073741824 &&
             result.unit_y <= 32'sd1073741824 && result.unit_y >= -32'sd1073741824 &&
             result.unit_z <= 32'sd1073741824 && result.unit_z >= -32'sd1073741824)
    else $error("normal component outside unit range");
`endif

endmodule

[tb/sv/tb_triangle_normal_and_area_top.sv]
// ---------------------------------------------------------------------------
// tb_triangle_normal_and_area_top
// Self-checking bench for the triangle unit normal and area pipeline: an
// in-bench predictor computes normal, area and degenerate flag per beat, and
// a scoreboard compares every done beat against the oldest prediction.
// ---------------------------------------------------------------------------
module tb_triangle_normal_and_area_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tnaa_pkg::*;

  localparam int LatencyCyc = 101;
  localparam int CycleLimit = 400000;

  // Exact integer square root, truncated.
  function automatic logic [127:0] int_sqrt(input logic [127:0] x);
    logic [127:0] root;
    logic [127:0] bitv;
    logic [127:0] trial;
    root = '0;
    bitv = 128'd1 << 126;
    while (bitv != 0) begin
      trial = root + bitv;
      if (x >= trial) begin
        x = x - trial;
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic tri_out_t predict_normal_area(input tri_in_t v);
    logic signed [63:0] ax, ay, az, bx, by, bz;
    logic signed [63:0] c [3];
    logic [63:0] m;
    logic [127:0] lensq, root, quo;
    tri_out_t r;
    ax = 64'(v.p1_x) - 64'(v.p0_x);
    ay = 64'(v.p1_y) - 64'(v.p0_y);
    az = 64'(v.p1_z) - 64'(v.p0_z);
    bx = 64'(v.p2_x) - 64'(v.p0_x);
    by = 64'(v.p2_y) - 64'(v.p0_y);
    bz = 64'(v.p2_z) - 64'(v.p0_z);
    c[0] = ay * bz - az * by;
    c[1] = az * bx - ax * bz;
    c[2] = ax * by - ay * bx;
    lensq = '0;
    for (int k = 0; k < 3; k++) begin
      m = (c[k] < 0) ? -c[k] : c[k];
      lensq += 128'(m) * 128'(m);
    end
    r = '0;
    if (lensq == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    root = int_sqrt(lensq << 26);
    for (int k = 0; k < 3; k++) begin
      m = (c[k] < 0) ? -c[k] : c[k];
      quo = (128'(m) << 43) / root;
      if (c[k] < 0) quo = -quo;
      case (k)
        0: r.unit_x = quo[31:0];
        1: r.unit_y = quo[31:0];
        default: r.unit_z = quo[31:0];
      endcase
    end
    r.tri_area = AreaW'(int_sqrt(lensq >> 2));
    return r;
  endfunction

  class normal_scoreboard;
    tri_out_t pending[$];
    int errors;

    function void note_triangle(tri_in_t v);
      pending.push_back(predict_normal_area(v));
    endfunction

    function void check_result(tri_out_t got);
      tri_out_t want;
      if (pending.size() == 0) begin
        $error("unexpected result beat");
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.unit_x !== want.unit_x) begin
        $error("unit_x exp %0d got %0d", want.unit_x, got.unit_x); errors++;
      end
      if (got.unit_y !== want.unit_y) begin
        $error("unit_y exp %0d got %0d", want.unit_y, got.unit_y); errors++;
      end
      if (got.unit_z !== want.unit_z) begin
        $error("unit_z exp %0d got %0d", want.unit_z, got.unit_z); errors++;
      end
      if (got.tri_area !== want.tri_area) begin
        $error("tri_area exp %0d got %0d", want.tri_area, got.tri_area); errors++;
      end
      if (got.degenerate !== want.degenerate) begin
        $error("degenerate exp %0b got %0b", want.degenerate, got.degenerate); errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  tri_in_t vertices;
  logic done;
  tri_out_t result;
  normal_scoreboard board;
  int cycles;
  int idle_pct;

  triangle_normal_and_area_top i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .vertices(vertices), .done(done), .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done) board.check_result(result);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'(int'($urandom_range(0, 64)) - 32);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic tri_in_t rand_triangle();
    tri_in_t v;
    v = {9{24'h0}};
    v.p0_x = rand_coord(); v.p0_y = rand_coord(); v.p0_z = rand_coord();
    v.p1_x = rand_coord(); v.p1_y = rand_coord(); v.p1_z = rand_coord();
    v.p2_x = rand_coord(); v.p2_y = rand_coord(); v.p2_z = rand_coord();
    case ($urandom_range(0, 9))
      0: v.p1_x = v.p0_x;                      // shared x coordinate
      1: begin v.p1_x = v.p0_x; v.p1_y = v.p0_y; v.p1_z = v.p0_z; end
      2: begin                                 // coincident: p2 on top of p0
        v.p2_x = v.p0_x; v.p2_y = v.p0_y; v.p2_z = v.p0_z;
      end
      default: ;
    endcase
    return v;
  endfunction

  // Present one beat and hold it until taken.
  task automatic send_triangle(input tri_in_t v);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    vertices <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_triangle(v);
  endtask

  task automatic drain_pipe();
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LatencyCyc + 5) @(posedge clk);
  endtask

  initial begin
    tri_in_t v;
    board = new();
    idle_pct = 0;
    rst = 1'b1;
    start = 1'b0;
    vertices = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: all-zero, extremes, axis-aligned and coincident cases
    send_triangle('0);
    send_triangle({9{24'h7FFFFF}});
    v = '0; v.p1_x = 24'h010000; v.p2_y = 24'h010000;
    send_triangle(v);
    v = '0; v.p1_y = 24'h010000; v.p2_z = 24'h010000;
    send_triangle(v);
    v = '0; v.p1_z = 24'h010000; v.p2_x = 24'h010000;
    send_triangle(v);
    v = '0; v.p1_x = 24'h000001; v.p2_y = 24'h000001;
    send_triangle(v);
    v = {24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h800000,
         24'h800000, 24'h7FFFFF, 24'h800000};
    send_triangle(v);
    v = {24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h7FFFFF,
         24'h7FFFFF, 24'h7FFFFF, 24'h800000};
    send_triangle(v);
    v = {24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000,
         24'h800000, 24'h7FFFFF, 24'h7FFFFF};
    send_triangle(v);
    v = '0; v.p1_x = 24'h020000; v.p1_y = 24'h020000; v.p2_x = 24'h040000;
    v.p2_y = 24'h040000;
    send_triangle(v);
    v = {9{24'hFFFFFF}}; v.p2_z = 24'h7FFFFF;
    send_triangle(v);
    // hold off until the pipe is empty
    drain_pipe();

    idle_pct = 24;
    repeat (430) send_triangle(rand_triangle());
    idle_pct = 50;
    repeat (430) send_triangle(rand_triangle());
    idle_pct = 0;
    repeat (430) send_triangle(rand_triangle());
    drain_pipe();

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
